[rtl/aes_pad_pkg.sv]
// Types, S-box and round helpers for the padded AES-128 ECB encryptor.
`default_nettype none
package aes_pad_pkg;

	localparam int BlockBytes = 16;
	localparam logic [7:0] PadMark = 8'h80;
	localparam int Rounds = 10;

	typedef enum logic [0:0] {
		REG_KEY_HIGH = 1'b0,
		REG_KEY_LOW  = 1'b1
	} reg_idx_t;

	typedef logic [127:0] block_t;

	function automatic logic [7:0] sbox(input logic [7:0] x);
		logic [7:0] r;
		case (x)
			8'h00: r = 8'h63; 8'h01: r = 8'h7c; 8'h02: r = 8'h77; 8'h03: r = 8'h7b;
			8'h04: r = 8'hf2; 8'h05: r = 8'h6b; 8'h06: r = 8'h6f; 8'h07: r = 8'hc5;
			8'h08: r = 8'h30; 8'h09: r = 8'h01; 8'h0a: r = 8'h67; 8'h0b: r = 8'h2b;
			8'h0c: r = 8'hfe; 8'h0d: r = 8'hd7; 8'h0e: r = 8'hab; 8'h0f: r = 8'h76;
			8'h10: r = 8'hca; 8'h11: r = 8'h82; 8'h12: r = 8'hc9; 8'h13: r = 8'h7d;
			8'h14: r = 8'hfa; 8'h15: r = 8'h59; 8'h16: r = 8'h47; 8'h17: r = 8'hf0;
			8'h18: r = 8'had; 8'h19: r = 8'hd4; 8'h1a: r = 8'ha2; 8'h1b: r = 8'haf;
			8'h1c: r = 8'h9c; 8'h1d: r = 8'ha4; 8'h1e: r = 8'h72; 8'h1f: r = 8'hc0;
			8'h20: r = 8'hb7; 8'h21: r = 8'hfd; 8'h22: r = 8'h93; 8'h23: r = 8'h26;
			8'h24: r = 8'h36; 8'h25: r = 8'h3f; 8'h26: r = 8'hf7; 8'h27: r = 8'hcc;
			8'h28: r = 8'h34; 8'h29: r = 8'ha5; 8'h2a: r = 8'he5; 8'h2b: r = 8'hf1;
			8'h2c: r = 8'h71; 8'h2d: r = 8'hd8; 8'h2e: r = 8'h31; 8'h2f: r = 8'h15;
			8'h30: r = 8'h04; 8'h31: r = 8'hc7; 8'h32: r = 8'h23; 8'h33: r = 8'hc3;
			8'h34: r = 8'h18; 8'h35: r = 8'h96; 8'h36: r = 8'h05; 8'h37: r = 8'h9a;
			8'h38: r = 8'h07; 8'h39: r = 8'h12; 8'h3a: r = 8'h80; 8'h3b: r = 8'he2;
			8'h3c: r = 8'heb; 8'h3d: r = 8'h27; 8'h3e: r = 8'hb2; 8'h3f: r = 8'h75;
			8'h40: r = 8'h09; 8'h41: r = 8'h83; 8'h42: r = 8'h2c; 8'h43: r = 8'h1a;
			8'h44: r = 8'h1b; 8'h45: r = 8'h6e; 8'h46: r = 8'h5a; 8'h47: r = 8'ha0;
			8'h48: r = 8'h52; 8'h49: r = 8'h3b; 8'h4a: r = 8'hd6; 8'h4b: r = 8'hb3;
			8'h4c: r = 8'h29; 8'h4d: r = 8'he3; 8'h4e: r = 8'h2f; 8'h4f: r = 8'h84;
			8'h50: r = 8'h53; 8'h51: r = 8'hd1; 8'h52: r = 8'h00; 8'h53: r = 8'hed;
			8'h54: r = 8'h20; 8'h55: r = 8'hfc; 8'h56: r = 8'hb1; 8'h57: r = 8'h5b;
			8'h58: r = 8'h6a; 8'h59: r = 8'hcb; 8'h5a: r = 8'hbe; 8'h5b: r = 8'h39;
			8'h5c: r = 8'h4a; 8'h5d: r = 8'h4c; 8'h5e: r = 8'h58; 8'h5f: r = 8'hcf;
			8'h60: r = 8'hd0; 8'h61: r = 8'hef; 8'h62: r = 8'haa; 8'h63: r = 8'hfb;
			8'h64: r = 8'h43; 8'h65: r = 8'h4d; 8'h66: r = 8'h33; 8'h67: r = 8'h85;
			8'h68: r = 8'h45; 8'h69: r = 8'hf9; 8'h6a: r = 8'h02; 8'h6b: r = 8'h7f;
			8'h6c: r = 8'h50; 8'h6d: r = 8'h3c; 8'h6e: r = 8'h9f; 8'h6f: r = 8'ha8;
			8'h70: r = 8'h51; 8'h71: r = 8'ha3; 8'h72: r = 8'h40; 8'h73: r = 8'h8f;
			8'h74: r = 8'h92; 8'h75: r = 8'h9d; 8'h76: r = 8'h38; 8'h77: r = 8'hf5;
			8'h78: r = 8'hbc; 8'h79: r = 8'hb6; 8'h7a: r = 8'hda; 8'h7b: r = 8'h21;
			8'h7c: r = 8'h10; 8'h7d: r = 8'hff; 8'h7e: r = 8'hf3; 8'h7f: r = 8'hd2;
			8'h80: r = 8'hcd; 8'h81: r = 8'h0c; 8'h82: r = 8'h13; 8'h83: r = 8'hec;
			8'h84: r = 8'h5f; 8'h85: r = 8'h97; 8'h86: r = 8'h44; 8'h87: r = 8'h17;
			8'h88: r = 8'hc4; 8'h89: r = 8'ha7; 8'h8a: r = 8'h7e; 8'h8b: r = 8'h3d;
			8'h8c: r = 8'h64; 8'h8d: r = 8'h5d; 8'h8e: r = 8'h19; 8'h8f: r = 8'h73;
			8'h90: r = 8'h60; 8'h91: r = 8'h81; 8'h92: r = 8'h4f; 8'h93: r = 8'hdc;
			8'h94: r = 8'h22; 8'h95: r = 8'h2a; 8'h96: r = 8'h90; 8'h97: r = 8'h88;
			8'h98: r = 8'h46; 8'h99: r = 8'hee; 8'h9a: r = 8'hb8; 8'h9b: r = 8'h14;
			8'h9c: r = 8'hde; 8'h9d: r = 8'h5e; 8'h9e: r = 8'h0b; 8'h9f: r = 8'hdb;
			8'ha0: r = 8'he0; 8'ha1: r = 8'h32; 8'ha2: r = 8'h3a; 8'ha3: r = 8'h0a;
			8'ha4: r = 8'h49; 8'ha5: r = 8'h06; 8'ha6: r = 8'h24; 8'ha7: r = 8'h5c;
			8'ha8: r = 8'hc2; 8'ha9: r = 8'hd3; 8'haa: r = 8'hac; 8'hab: r = 8'h62;
			8'hac: r = 8'h91; 8'had: r = 8'h95; 8'hae: r = 8'he4; 8'haf: r = 8'h79;
			8'hb0: r = 8'he7; 8'hb1: r = 8'hc8; 8'hb2: r = 8'h37; 8'hb3: r = 8'h6d;
			8'hb4: r = 8'h8d; 8'hb5: r = 8'hd5; 8'hb6: r = 8'h4e; 8'hb7: r = 8'ha9;
			8'hb8: r = 8'h6c; 8'hb9: r = 8'h56; 8'hba: r = 8'hf4; 8'hbb: r = 8'hea;
			8'hbc: r = 8'h65; 8'hbd: r = 8'h7a; 8'hbe: r = 8'hae; 8'hbf: r = 8'h08;
			8'hc0: r = 8'hba; 8'hc1: r = 8'h78; 8'hc2: r = 8'h25; 8'hc3: r = 8'h2e;
			8'hc4: r = 8'h1c; 8'hc5: r = 8'ha6; 8'hc6: r = 8'hb4; 8'hc7: r = 8'hc6;
			8'hc8: r = 8'he8; 8'hc9: r = 8'hdd; 8'hca: r = 8'h74; 8'hcb: r = 8'h1f;
			8'hcc: r = 8'h4b; 8'hcd: r = 8'hbd; 8'hce: r = 8'h8b; 8'hcf: r = 8'h8a;
			8'hd0: r = 8'h70; 8'hd1: r = 8'h3e; 8'hd2: r = 8'hb5; 8'hd3: r = 8'h66;
			8'hd4: r = 8'h48; 8'hd5: r = 8'h03; 8'hd6: r = 8'hf6; 8'hd7: r = 8'h0e;
			8'hd8: r = 8'h61; 8'hd9: r = 8'h35; 8'hda: r = 8'h57; 8'hdb: r = 8'hb9;
			8'hdc: r = 8'h86; 8'hdd: r = 8'hc1; 8'hde: r = 8'h1d; 8'hdf: r = 8'h9e;
			8'he0: r = 8'he1; 8'he1: r = 8'hf8; 8'he2: r = 8'h98; 8'he3: r = 8'h11;
			8'he4: r = 8'h69; 8'he5: r = 8'hd9; 8'he6: r = 8'h8e; 8'he7: r = 8'h94;
			8'he8: r = 8'h9b; 8'he9: r = 8'h1e; 8'hea: r = 8'h87; 8'heb: r = 8'he9;
			8'hec: r = 8'hce; 8'hed: r = 8'h55; 8'hee: r = 8'h28; 8'hef: r = 8'hdf;
			8'hf0: r = 8'h8c; 8'hf1: r = 8'ha1; 8'hf2: r = 8'h89; 8'hf3: r = 8'h0d;
			8'hf4: r = 8'hbf; 8'hf5: r = 8'he6; 8'hf6: r = 8'h42; 8'hf7: r = 8'h68;
			8'hf8: r = 8'h41; 8'hf9: r = 8'h99; 8'hfa: r = 8'h2d; 8'hfb: r = 8'h0f;
			8'hfc: r = 8'hb0; 8'hfd: r = 8'h54; 8'hfe: r = 8'hbb; 8'hff: r = 8'h16;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// Round constant for key expansion round 1..10
	function automatic logic [7:0] rcon(input logic [3:0] rnd);
		logic [7:0] r;
		case (rnd)
			4'd1: r = 8'h01; 4'd2: r = 8'h02; 4'd3: r = 8'h04; 4'd4: r = 8'h08;
			4'd5: r = 8'h10; 4'd6: r = 8'h20; 4'd7: r = 8'h40; 4'd8: r = 8'h80;
			4'd9: r = 8'h1b; 4'd10: r = 8'h36;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	// Byte i of a block, byte 0 in the top bits
	function automatic logic [7:0] byte_of(input block_t b, input int i);
		return b[127 - 8*i -: 8];
	endfunction

	// Next round key from the previous one
	function automatic block_t next_key(input block_t k, input logic [3:0] rnd);
		block_t n;
		logic [31:0] w0, w1, w2, w3, t;
		w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
		t = {sbox(w3[23:16]) ^ rcon(rnd), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
		w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
		n = {w0, w1, w2, w3};
		return n;
	endfunction

	// SubBytes and ShiftRows, optionally MixColumns
	function automatic block_t round_fn(input block_t s, input logic mix);
		block_t t, m;
		logic [7:0] a0, a1, a2, a3, al;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[127 - 8*(c*4 + r) -: 8] = sbox(byte_of(s, ((c + r) % 4) * 4 + r));
			end
		end
		m = t;
		for (int c = 0; c < 4; c++) begin
			a0 = byte_of(t, c*4); a1 = byte_of(t, c*4 + 1);
			a2 = byte_of(t, c*4 + 2); a3 = byte_of(t, c*4 + 3);
			al = a0 ^ a1 ^ a2 ^ a3;
			m[127 - 8*(c*4) -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
			m[127 - 8*(c*4 + 1) -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
			m[127 - 8*(c*4 + 2) -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
			m[127 - 8*(c*4 + 3) -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
		end
		return mix ? m : t;
	endfunction

endpackage
`default_nettype wire

[rtl/aes128_ecb_pad_encrypt.sv]
// Pipelined AES-128 ECB encryptor with 0x80 padding of a short last block.
// Eleven register stages (stage 0 pads and adds the key, stages 1 to 10 each run
// one AES round); the result is taken from stage 10.
// Throughput: one block per cycle unless out_stall holds the pipe; the key schedule
// is expanded alongside in each stage so the key travels with its block.
// A stall from the output holds the valid stages back to the first empty slot; bubbles are squeezed out.
// Reset clears stage valid bits and both key registers to zero.
`default_nettype none
module aes128_ecb_pad_encrypt (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [63:0] plain_high,
	input  wire logic [63:0] plain_low,
	input  wire logic [4:0]  valid_bytes,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [63:0]      cipher_high,
	output logic [63:0]      cipher_low,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);

	localparam int NStage = aes_pad_pkg::Rounds + 1;

	logic [63:0] key_high_q, key_low_q;
	aes_pad_pkg::block_t st_s [NStage];
	aes_pad_pkg::block_t rk_s [NStage];
	logic [NStage-1:0] vld_s;
	logic [NStage-1:0] adv;
	aes_pad_pkg::block_t padded;

	assign cfg_ready = 1'b1;

	// Hold key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q <= '0;
		end else if (cfg_valid) begin
			unique case (aes_pad_pkg::reg_idx_t'(cfg_index))
				aes_pad_pkg::REG_KEY_HIGH: key_high_q <= cfg_data;
				aes_pad_pkg::REG_KEY_LOW:  key_low_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance a stage when its slot is empty or the one after it moves
	always_comb begin
		adv[NStage-1] = !vld_s[NStage-1] || !out_stall;
		for (int i = NStage - 2; i >= 0; i--) begin
			adv[i] = !vld_s[i] || adv[i+1];
		end
	end
	assign in_stall = !adv[0];

	// Clear bytes past the count and drop the pad mark in
	always_comb begin
		padded = {plain_high, plain_low};
		if (valid_bytes < 5'(aes_pad_pkg::BlockBytes)) begin
			for (int i = 0; i < aes_pad_pkg::BlockBytes; i++) begin
				if (5'(i) == valid_bytes) begin
					padded[127 - 8*i -: 8] = aes_pad_pkg::PadMark;
				end else if (5'(i) > valid_bytes) begin
					padded[127 - 8*i -: 8] = 8'h00;
				end
			end
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[0]) vld_s[0] <= in_valid;
			for (int i = 1; i < NStage; i++) begin
				if (adv[i]) vld_s[i] <= vld_s[i-1];
			end
		end
	end

	// Data stages: initial key add, then one round per stage
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			st_s[0] <= padded ^ {key_high_q, key_low_q};
			rk_s[0] <= {key_high_q, key_low_q};
		end
		for (int i = 1; i < NStage; i++) begin
			if (adv[i]) begin
				rk_s[i] <= aes_pad_pkg::next_key(rk_s[i-1], 4'(i));
				st_s[i] <= aes_pad_pkg::round_fn(st_s[i-1], i != NStage - 1)
					^ aes_pad_pkg::next_key(rk_s[i-1], 4'(i));
			end
		end
	end

	assign out_valid = vld_s[NStage-1];
	assign cipher_high = st_s[NStage-1][127:64];
	assign cipher_low = st_s[NStage-1][63:0];

	// A held result stays put while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(cipher_high) && $stable(cipher_low))
		else $error("result changed under stall");
	// Input is refused only when the whole pipe is full
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (&vld_s) && out_stall)
		else $error("input stalled with a free slot");
	// An item in the last-but-one stage reaches the output when not blocked
	a_move: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[NStage-2] && !out_stall |=> out_valid)
		else $error("item lost in final stage");

endmodule
`default_nettype wire
